[rtl/wmr_pkg.sv]
//------------------------------------------------------------------------------
// wmr_pkg
// Shared constants and types for the windowed median range block.
//------------------------------------------------------------------------------
package wmr_pkg;

   localparam int MAX_RADIUS  = 7;
   localparam int STORE_DEPTH = 256;
   localparam int COORD_BITS  = 16;

   localparam int RANGE_BITS  = 16;
   localparam int PIX_BITS    = 12;
   localparam int RADIUS_BITS = 3;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX    = 2'd2;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 3'd3;
   localparam logic [RANGE_BITS-1:0]  MIN_RST    = 16'd200;
   localparam logic [RANGE_BITS-1:0]  MAX_RST    = 16'd10000;

   // status handed from the front end to the selector
   typedef struct packed {
      logic wr_en;
      logic last;
   } front_stat_type;

endpackage

[rtl/wmr_ram.sv]
//------------------------------------------------------------------------------
// wmr_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
module wmr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/wmr_front.sv]
//------------------------------------------------------------------------------
// wmr_front
// Window test and pipelined distance: squares, sum, then a restoring
// square root unrolled over register stages (one result bit per stage).
//------------------------------------------------------------------------------
module wmr_front #(
   parameter int COORD_BITS = wmr_pkg::COORD_BITS,
   parameter int MAX_RADIUS = wmr_pkg::MAX_RADIUS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [wmr_pkg::PIX_BITS-1:0]        pixel_col,
   input  logic [wmr_pkg::PIX_BITS-1:0]        pixel_row,
   input  logic [wmr_pkg::PIX_BITS-1:0]        center_col,
   input  logic [wmr_pkg::PIX_BITS-1:0]        center_row,
   input  logic [COORD_BITS-1:0]               pos_x,
   input  logic [COORD_BITS-1:0]               pos_y,
   input  logic [COORD_BITS-1:0]               pos_z,
   input  logic                                point_finite,
   input  logic                                frame_last,
   input  logic [wmr_pkg::RADIUS_BITS-1:0]     radius,
   input  logic [wmr_pkg::RANGE_BITS-1:0]      min_range,
   input  logic [wmr_pkg::RANGE_BITS-1:0]      max_range,
   output logic                                out_valid,
   output wmr_pkg::front_stat_type             out_stat,
   output logic [wmr_pkg::RANGE_BITS-1:0]      out_dist
);

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 2;
   localparam int RT_BITS  = SUM_BITS / 2;          // SUM_BITS is even
   localparam int NSTAGE   = RT_BITS;               // one result bit per stage
   localparam int RW       = wmr_pkg::RANGE_BITS;

   // ---------------- stage 0: window test and magnitudes
   localparam int RADIUS_BITS_L = wmr_pkg::RADIUS_BITS;
   logic [RADIUS_BITS_L-1:0] r_cap;
   logic [wmr_pkg::PIX_BITS-1:0] dc, dr;
   logic win_hit;
   logic [COORD_BITS-1:0] mx, my, mz;

   always_comb begin
      r_cap = (radius > RADIUS_BITS_L'(MAX_RADIUS)) ? RADIUS_BITS_L'(MAX_RADIUS) : radius;
      dc = (pixel_col >= center_col) ? pixel_col - center_col : center_col - pixel_col;
      dr = (pixel_row >= center_row) ? pixel_row - center_row : center_row - pixel_row;
      win_hit = (dc <= wmr_pkg::PIX_BITS'(r_cap)) && (dr <= wmr_pkg::PIX_BITS'(r_cap));
      mx = pos_x[COORD_BITS-1] ? COORD_BITS'(~pos_x + 1'b1) : pos_x;
      my = pos_y[COORD_BITS-1] ? COORD_BITS'(~pos_y + 1'b1) : pos_y;
      mz = pos_z[COORD_BITS-1] ? COORD_BITS'(~pos_z + 1'b1) : pos_z;
   end

   // most negative value keeps magnitude 2^(N-1) via the extra bit
   logic [COORD_BITS:0] ex, ey, ez;
   assign ex = {pos_x[COORD_BITS-1] & (mx == {1'b1, {(COORD_BITS-1){1'b0}}}), mx};
   assign ey = {pos_y[COORD_BITS-1] & (my == {1'b1, {(COORD_BITS-1){1'b0}}}), my};
   assign ez = {pos_z[COORD_BITS-1] & (mz == {1'b1, {(COORD_BITS-1){1'b0}}}), mz};

   logic s1_v_ff, s1_use_ff, s1_last_ff;
   logic [SQ_BITS:0] sx_ff, sy_ff, sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
      end
      s1_use_ff  <= win_hit & point_finite;
      s1_last_ff <= frame_last;
      sx_ff <= (SQ_BITS+1)'({ex[COORD_BITS-1:0]} * {ex[COORD_BITS-1:0]})
               | (ex[COORD_BITS] ? (SQ_BITS+1)'(1) << (SQ_BITS-2) : '0);
      sy_ff <= (SQ_BITS+1)'({ey[COORD_BITS-1:0]} * {ey[COORD_BITS-1:0]})
               | (ey[COORD_BITS] ? (SQ_BITS+1)'(1) << (SQ_BITS-2) : '0);
      sz_ff <= (SQ_BITS+1)'({ez[COORD_BITS-1:0]} * {ez[COORD_BITS-1:0]})
               | (ez[COORD_BITS] ? (SQ_BITS+1)'(1) << (SQ_BITS-2) : '0);
   end

   // ---------------- stage 2: sum
   logic s2_v_ff, s2_use_ff, s2_last_ff;
   logic [SUM_BITS-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_use_ff  <= s1_use_ff;
      s2_last_ff <= s1_last_ff;
      sum_ff <= SUM_BITS'(sx_ff) + SUM_BITS'(sy_ff) + SUM_BITS'(sz_ff);
   end

   // ---------------- square root stages, one root bit each
   logic                v_ff    [NSTAGE+1];
   logic                use_ff  [NSTAGE+1];
   logic                last_ff [NSTAGE+1];
   logic [SUM_BITS-1:0] rem_ff  [NSTAGE+1];
   logic [RT_BITS-1:0]  root_ff [NSTAGE+1];

   always_comb begin
      v_ff[0]    = s2_v_ff;
      use_ff[0]  = s2_use_ff;
      last_ff[0] = s2_last_ff;
      rem_ff[0]  = sum_ff;
      root_ff[0] = '0;
   end

   for (genvar g = 0; g < NSTAGE; g++) begin : g_sqrt
      localparam int B = NSTAGE - 1 - g;   // root bit decided here
      logic [SUM_BITS+1:0] trial;
      logic [SUM_BITS+1:0] r_ext;
      logic [SUM_BITS+1:0] rm;
      logic                v_q, use_q, last_q;
      logic [SUM_BITS-1:0] rem_q;
      logic [RT_BITS-1:0]  root_q;

      // trial = (2*root + 2^B) << B  where root holds higher bits only
      assign r_ext = (SUM_BITS+2)'(root_ff[g]);
      assign trial = (r_ext << (B + 1)) + ((SUM_BITS+2)'(1) << (2 * B));
      assign rm    = (SUM_BITS+2)'(rem_ff[g]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_q <= 1'b0;
         end else begin
            v_q <= v_ff[g];
         end
         use_q  <= use_ff[g];
         last_q <= last_ff[g];
         if (rm >= trial) begin
            rem_q  <= SUM_BITS'(rm - trial);
            root_q <= root_ff[g] | (RT_BITS'(1) << B);
         end else begin
            rem_q  <= rem_ff[g];
            root_q <= root_ff[g];
         end
      end

      always_comb begin
         v_ff[g+1]    = v_q;
         use_ff[g+1]  = use_q;
         last_ff[g+1] = last_q;
         rem_ff[g+1]  = rem_q;
         root_ff[g+1] = root_q;
      end
   end

   // ---------------- saturate and bound test
   logic [RT_BITS-1:0] root_f;
   logic [RW-1:0]      dist_sat;
   assign root_f = root_ff[NSTAGE];

   always_comb begin
      if (RT_BITS > RW && (root_f >> RW) != '0) begin
         dist_sat = '1;
      end else begin
         dist_sat = RW'(root_f);
      end
      out_valid       = v_ff[NSTAGE];
      out_dist        = dist_sat;
      out_stat.last   = last_ff[NSTAGE];
      out_stat.wr_en  = use_ff[NSTAGE] && dist_sat >= min_range && dist_sat <= max_range;
   end

endmodule

[rtl/wmr_select.sv]
//------------------------------------------------------------------------------
// wmr_select
// Store of accepted distances and frame-end median search. The median is
// found by a bitwise radix search: for each result bit from the top, one
// pass over the store counts entries below the candidate prefix.
//------------------------------------------------------------------------------
module wmr_select #(
   parameter int STORE_DEPTH = wmr_pkg::STORE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  wmr_pkg::front_stat_type         in_stat,
   input  logic [wmr_pkg::RANGE_BITS-1:0]  in_dist,
   output logic                            busy,
   output logic                            res_valid,
   output logic [wmr_pkg::RANGE_BITS-1:0]  res_median,
   output logic                            res_found,
   input  logic                            res_taken
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int RW = wmr_pkg::RANGE_BITS;
   localparam int BW = $clog2(RW);

   typedef enum logic [3:0] {
      ST_FILL  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     addr_ff, addr_in;     // next read address in scan
   logic [CW-1:0]     below_ff, below_in;   // entries below trial value
   logic [RW-1:0]     prefix_ff, prefix_in; // median bits decided so far
   logic [BW-1:0]     bit_ff, bit_in;
   logic              rd_v_ff, rd_v_in;
   logic              ov_ff, ov_in;
   logic [RW-1:0]     omed_ff, omed_in;
   logic              ofnd_ff, ofnd_in;

   logic              wr_en;
   logic [RW-1:0]     rd_data;
   logic [RW-1:0]     trial;
   logic [CW-1:0]     half;

   assign wr_en = in_valid && in_stat.wr_en && (count_ff < CW'(STORE_DEPTH))
                  && state_ff == ST_FILL;
   assign trial = prefix_ff | (RW'(1) << bit_ff);
   assign half  = count_ff >> 1;

   wmr_ram #(.WIDTH(RW), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (in_dist),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // control
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      below_in  = below_ff;
      prefix_in = prefix_ff;
      bit_in    = bit_ff;
      rd_v_in   = 1'b0;
      ov_in     = ov_ff;
      omed_in   = omed_ff;
      ofnd_in   = ofnd_ff;
      if (res_valid && res_taken) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         ST_FILL: begin
            if (wr_en) begin
               count_in = count_ff + 1'b1;
            end
            if (in_valid && in_stat.last) begin
               addr_in   = '0;
               below_in  = '0;
               prefix_in = '0;
               bit_in    = BW'(RW - 1);
               // empty frame goes straight out with a zero median
               if (count_in == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue reads; count entries below trial as data returns
            if (rd_v_ff && rd_data < trial) begin
               below_in = below_ff + 1'b1;
            end
            if (addr_ff < count_ff) begin
               addr_in = addr_ff + 1'b1;
               rd_v_in = 1'b1;
            end else if (!rd_v_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // below <= half means the median is at least trial
            if (below_ff <= half) begin
               prefix_in = trial;
            end
            below_in = '0;
            addr_in  = '0;
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_OUT: begin
            // load the result register only once it is free
            if (!ov_ff || (res_valid && res_taken)) begin
               ov_in    = 1'b1;
               omed_in  = prefix_ff;
               ofnd_in  = (count_ff != '0);
               count_in = '0;
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         rd_v_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_v_ff  <= rd_v_in;
         ov_ff    <= ov_in;
      end
      addr_ff   <= addr_in;
      below_ff  <= below_in;
      prefix_ff <= prefix_in;
      bit_ff    <= bit_in;
      omed_ff   <= omed_in;
      ofnd_ff   <= ofnd_in;
   end

   assign busy       = state_ff != ST_FILL;
   assign res_valid  = ov_ff;
   assign res_median = omed_ff;
   assign res_found  = ofnd_ff;

endmodule

[rtl/window_median_range.sv]
//------------------------------------------------------------------------------
// window_median_range
// Windowed upper-median distance over a frame of 3D points.
//------------------------------------------------------------------------------
// Points enter on req_ (one per cycle while the store is filling). Points in
// the square window around the center that are finite get their floor
// distance from a pipelined square root; those within [min,max] go to a
// 256-entry RAM. Once the point marked frame_last is taken, req_tready stays
// low while that point drains from the pipeline and the block runs a radix
// median search of 16 passes over the store, which has a single read port.
// One result appears on rsp_ per frame; it sits in an output register until
// taken, and a new frame may fill while it waits. A stalled receiver holds
// off intake only at the next frame end, until the waiting result is taken.
// Reset (synchronous) restores the register defaults and empties the store;
// no clearing pass is needed.
// Configuration is written on csr_ at any edge with csr_wr_en high.
//------------------------------------------------------------------------------
module window_median_range #(
   parameter int MAX_RADIUS  = wmr_pkg::MAX_RADIUS,
   parameter int STORE_DEPTH = wmr_pkg::STORE_DEPTH,
   parameter int COORD_BITS  = wmr_pkg::COORD_BITS
) (
   input  logic clock,
   input  logic reset,
   // tdata: pixel_col, pixel_row, center_col, center_row, pos_x, pos_y,
   //        pos_z, point_finite (lowest bit first), zero fill
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((48 + 3*COORD_BITS + 1 + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tlast,
   // tdata: median_mm, found
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [wmr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int PB = wmr_pkg::PIX_BITS;
   localparam int CB = COORD_BITS;
   localparam int RW = wmr_pkg::RANGE_BITS;

   logic [wmr_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [RW-1:0] min_ff, max_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= wmr_pkg::RADIUS_RST;
         min_ff    <= wmr_pkg::MIN_RST;
         max_ff    <= wmr_pkg::MAX_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            wmr_pkg::CSR_RADIUS: radius_ff <= csr_wdata[wmr_pkg::RADIUS_BITS-1:0];
            wmr_pkg::CSR_MIN:    min_ff    <= csr_wdata;
            wmr_pkg::CSR_MAX:    max_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic busy, acc;
   logic fe_v, res_median_found;
   wmr_pkg::front_stat_type fe_stat;
   logic [RW-1:0] fe_dist, med;

   // hold intake until a frame end has drained out of the distance pipeline
   logic last_inflight_ff;
   assign req_tready = !busy && !last_inflight_ff;
   assign acc        = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_inflight_ff <= 1'b0;
      end else if (acc && req_tlast) begin
         last_inflight_ff <= 1'b1;
      end else if (fe_v && fe_stat.last) begin
         last_inflight_ff <= 1'b0;
      end
   end

   wmr_front #(.COORD_BITS(CB), .MAX_RADIUS(MAX_RADIUS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (acc),
      .pixel_col    (req_tdata[PB-1:0]),
      .pixel_row    (req_tdata[2*PB-1:PB]),
      .center_col   (req_tdata[3*PB-1:2*PB]),
      .center_row   (req_tdata[4*PB-1:3*PB]),
      .pos_x        (req_tdata[4*PB+CB-1:4*PB]),
      .pos_y        (req_tdata[4*PB+2*CB-1:4*PB+CB]),
      .pos_z        (req_tdata[4*PB+3*CB-1:4*PB+2*CB]),
      .point_finite (req_tdata[4*PB+3*CB]),
      .frame_last   (req_tlast),
      .radius       (radius_ff),
      .min_range    (min_ff),
      .max_range    (max_ff),
      .out_valid    (fe_v),
      .out_stat     (fe_stat),
      .out_dist     (fe_dist)
   );

   wmr_select #(.STORE_DEPTH(STORE_DEPTH)) u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fe_v),
      .in_stat    (fe_stat),
      .in_dist    (fe_dist),
      .busy       (busy),
      .res_valid  (rsp_tvalid),
      .res_median (med),
      .res_found  (res_median_found),
      .res_taken  (rsp_tready)
   );

   assign rsp_tdata = {7'b0, res_median_found, med};

endmodule
